@@ sv/arpcr_pkg.sv @@
package arpcr_pkg;

   // Cache geometry
   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   // Field widths
   localparam int MAC_W = 48;
   localparam int IP_W  = 32;
   localparam int HDR_W = 16;

   // ARP header codes
   localparam logic [HDR_W-1:0] HTYPE_ETH     = 16'h0001;
   localparam logic [HDR_W-1:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [HDR_W-1:0] OP_REQUEST    = 16'h0001;
   localparam logic [HDR_W-1:0] OP_REPLY      = 16'h0002;
   localparam logic [HDR_W-1:0] ETHERTYPE_ARP = 16'h0806;

   // Item kinds
   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_MAC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP_0  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP_1  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP_CNT = 2'd3;

   // Cache memory word: IP in the upper bits, MAC in the lower bits
   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } entry_type;

endpackage

@@ sv/arp_cache_and_responder.sv @@
// Each item is handled by one pass over the cache memory through its single read port,
// one entry per cycle; the next item is taken only once that pass and the loading of
// its result into the output register are done.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears the valid bits, the configuration
// registers and the control state; cache memory contents are left as they are.
module arp_cache_and_responder (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [arpcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arpcr_pkg::MAC_W-1:0]        csr_wdata,
   // input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [arpcr_pkg::HDR_W-1:0]        req_hw_type,
   input  logic [arpcr_pkg::HDR_W-1:0]        req_proto_type,
   input  logic [arpcr_pkg::HDR_W-1:0]        req_oper_code,
   input  logic [arpcr_pkg::MAC_W-1:0]        req_sender_mac,
   input  logic [arpcr_pkg::IP_W-1:0]         req_sender_ip,
   input  logic [arpcr_pkg::IP_W-1:0]         req_target_ip,
   input  logic [arpcr_pkg::IP_W-1:0]         req_query_ip,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_reply_valid,
   output logic [arpcr_pkg::MAC_W-1:0]        rsp_reply_target_mac,
   output logic [arpcr_pkg::IP_W-1:0]         rsp_reply_target_ip,
   output logic [arpcr_pkg::MAC_W-1:0]        rsp_reply_sender_mac,
   output logic [arpcr_pkg::IP_W-1:0]         rsp_reply_sender_ip,
   output logic                               rsp_lookup_hit,
   output logic [arpcr_pkg::MAC_W-1:0]        rsp_lookup_mac,
   output logic                               rsp_insert_dropped
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam logic [arpcr_pkg::IDX_W-1:0] LAST_IDX =
      arpcr_pkg::IDX_W'(arpcr_pkg::CACHE_ENTRIES - 1);

   // Configuration registers
   logic [arpcr_pkg::MAC_W-1:0] local_mac_ff;
   logic [arpcr_pkg::IP_W-1:0]  local_ip_0_ff;
   logic [arpcr_pkg::IP_W-1:0]  local_ip_1_ff;
   logic [1:0]                  local_ip_cnt_ff;

   // Control
   state_type                         state_ff, state_in;
   logic [arpcr_pkg::IDX_W-1:0]       cnt_ff, cnt_in;
   logic [arpcr_pkg::CACHE_ENTRIES-1:0] entry_valid_ff;

   // Captured item
   logic                        item_kind_ff;
   logic [arpcr_pkg::HDR_W-1:0] item_hw_ff;
   logic [arpcr_pkg::HDR_W-1:0] item_proto_ff;
   logic [arpcr_pkg::HDR_W-1:0] item_oper_ff;
   logic [arpcr_pkg::MAC_W-1:0] item_smac_ff;
   logic [arpcr_pkg::IP_W-1:0]  item_sip_ff;
   logic [arpcr_pkg::IP_W-1:0]  item_tip_ff;
   logic [arpcr_pkg::IP_W-1:0]  item_qip_ff;

   // Read pipeline and scan results
   arpcr_pkg::entry_type              mem [arpcr_pkg::CACHE_ENTRIES];
   arpcr_pkg::entry_type              rd_data_ff;
   logic                              rd_vld_ff;
   logic                              rd_entry_ok_ff;
   logic [arpcr_pkg::IDX_W-1:0]       rd_idx_ff;
   logic                              found_ff;
   logic [arpcr_pkg::MAC_W-1:0]       hit_mac_ff;
   logic                              free_found_ff;
   logic [arpcr_pkg::IDX_W-1:0]       free_idx_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic                        rsp_reply_valid_ff;
   logic [arpcr_pkg::MAC_W-1:0] rsp_reply_target_mac_ff;
   logic [arpcr_pkg::IP_W-1:0]  rsp_reply_target_ip_ff;
   logic [arpcr_pkg::MAC_W-1:0] rsp_reply_sender_mac_ff;
   logic [arpcr_pkg::IP_W-1:0]  rsp_reply_sender_ip_ff;
   logic                        rsp_lookup_hit_ff;
   logic [arpcr_pkg::MAC_W-1:0] rsp_lookup_mac_ff;
   logic                        rsp_insert_dropped_ff;

   logic                        req_xfer;
   logic                        out_free;
   logic                        finish_go;
   logic [arpcr_pkg::IP_W-1:0]  scan_key;
   logic                        hdr_ok;
   logic                        op_ok;
   logic                        do_insert;
   logic                        is_local;
   logic                        reply_go;
   logic                        mem_we;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign scan_key  = (item_kind_ff == arpcr_pkg::KIND_LOOKUP) ? item_qip_ff : item_sip_ff;

   // Decode the finished item
   always_comb begin
      hdr_ok    = (item_hw_ff == arpcr_pkg::HTYPE_ETH) && (item_proto_ff == arpcr_pkg::PTYPE_IPV4);
      op_ok     = (item_oper_ff == arpcr_pkg::OP_REQUEST) || (item_oper_ff == arpcr_pkg::OP_REPLY);
      do_insert = (item_kind_ff == arpcr_pkg::KIND_PACKET) && hdr_ok && op_ok;
      is_local  = ((local_ip_cnt_ff != 2'd0) && (local_ip_0_ff == item_tip_ff)) ||
                  ((local_ip_cnt_ff[1])       && (local_ip_1_ff == item_tip_ff));
      reply_go  = do_insert && (item_oper_ff == arpcr_pkg::OP_REQUEST) && is_local;
      mem_we    = finish_go && do_insert && !found_ff && free_found_ff;
   end

   // Sequence one pass over the cache per item
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_mac_ff    <= '0;
         local_ip_0_ff   <= '0;
         local_ip_1_ff   <= '0;
         local_ip_cnt_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            arpcr_pkg::CSR_LOCAL_MAC:    local_mac_ff    <= csr_wdata;
            arpcr_pkg::CSR_LOCAL_IP_0:   local_ip_0_ff   <= csr_wdata[arpcr_pkg::IP_W-1:0];
            arpcr_pkg::CSR_LOCAL_IP_1:   local_ip_1_ff   <= csr_wdata[arpcr_pkg::IP_W-1:0];
            arpcr_pkg::CSR_LOCAL_IP_CNT: local_ip_cnt_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Capture the item on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_kind_ff  <= req_type;
         item_hw_ff    <= req_hw_type;
         item_proto_ff <= req_proto_type;
         item_oper_ff  <= req_oper_code;
         item_smac_ff  <= req_sender_mac;
         item_sip_ff   <= req_sender_ip;
         item_tip_ff   <= req_target_ip;
         item_qip_ff   <= req_query_ip;
      end
   end

   // Cache memory: one read port, one write port, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= '{ip: item_sip_ff, mac: item_smac_ff};
      end
      rd_data_ff <= mem[cnt_ff];
   end

   // Track which read is in flight and whether its entry is live
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_SCAN);
      end
      rd_idx_ff      <= cnt_ff;
      rd_entry_ok_ff <= entry_valid_ff[cnt_ff];
   end

   // Set the valid bit of a newly stored entry
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_we) begin
         entry_valid_ff[free_idx_ff] <= 1'b1;
      end
   end

   // Compare returned entries: keep the lowest hit and the lowest free slot
   always_ff @(posedge clock) begin
      if (reset || req_xfer) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_entry_ok_ff && (rd_data_ff.ip == scan_key) && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (!rd_entry_ok_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && rd_entry_ok_ff && (rd_data_ff.ip == scan_key) && !found_ff) begin
         hit_mac_ff <= rd_data_ff.mac;
      end
      if (rd_vld_ff && !rd_entry_ok_ff && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // Hold the result until the transfer on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_reply_valid_ff      <= reply_go;
         rsp_reply_target_mac_ff <= reply_go ? item_smac_ff : '0;
         rsp_reply_target_ip_ff  <= reply_go ? item_sip_ff : '0;
         rsp_reply_sender_mac_ff <= reply_go ? local_mac_ff : '0;
         rsp_reply_sender_ip_ff  <= reply_go ? item_tip_ff : '0;
         rsp_lookup_hit_ff       <= (item_kind_ff == arpcr_pkg::KIND_LOOKUP) && found_ff;
         rsp_lookup_mac_ff       <= ((item_kind_ff == arpcr_pkg::KIND_LOOKUP) && found_ff) ?
                                    hit_mac_ff : '0;
         rsp_insert_dropped_ff   <= do_insert && !found_ff && !free_found_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reply_valid      = rsp_reply_valid_ff;
   assign rsp_reply_target_mac = rsp_reply_target_mac_ff;
   assign rsp_reply_target_ip  = rsp_reply_target_ip_ff;
   assign rsp_reply_sender_mac = rsp_reply_sender_mac_ff;
   assign rsp_reply_sender_ip  = rsp_reply_sender_ip_ff;
   assign rsp_lookup_hit       = rsp_lookup_hit_ff;
   assign rsp_lookup_mac       = rsp_lookup_mac_ff;
   assign rsp_insert_dropped   = rsp_insert_dropped_ff;

`ifndef ASSERT_OFF
   // A store goes only to a slot that was free
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !entry_valid_ff[free_idx_ff])
      else $error("cache write to an occupied slot");

   // A dropped insert means every slot was occupied
   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (finish_go && do_insert && !found_ff && !free_found_ff) |-> (&entry_valid_ff))
      else $error("insert dropped while a slot was free");

   // Reads return only during the pass over the cache
   a_read_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("cache read data outside the scan");

   // A new result is loaded only when the previous one is gone or leaving
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_reply_target_mac_ff) &&
                                        $stable(rsp_lookup_mac_ff))
      else $error("pending result overwritten");
`endif

endmodule
